// ----- rtl/vceg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vceg_pkg;

    localparam int COORD_W    = 32;
    localparam int LEN_W      = 30;
    localparam int GRADE_W    = 32;
    localparam int GRADE_FRAC = 24;
    localparam int WIDE_W     = 64;
    localparam int IDX_W      = 4;
    localparam int NUM_REGS   = 8;
    localparam int DIV_STEPS  = 2 * WIDE_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam wide_t WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam wide_t WIDE_ONE = wide_t'(1);
    localparam wide_t GRADE_ONE = WIDE_ONE <<< GRADE_FRAC;
    localparam wide_t LEVEL_SCALE = WIDE_ONE <<< (GRADE_FRAC + 1);

    typedef enum logic [IDX_W-1:0] {
        REG_PBG_STA  = 4'd0,
        REG_PBG_ELEV = 4'd1,
        REG_PVI_STA  = 4'd2,
        REG_PVI_ELEV = 4'd3,
        REG_PFG_STA  = 4'd4,
        REG_PFG_ELEV = 4'd5,
        REG_LEN_ONE  = 4'd6,
        REG_LEN_TWO  = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pbg_sta;
        logic signed [COORD_W-1:0] pbg_elev;
        logic signed [COORD_W-1:0] pvi_sta;
        logic signed [COORD_W-1:0] pvi_elev;
        logic signed [COORD_W-1:0] pfg_sta;
        logic signed [COORD_W-1:0] pfg_elev;
        logic [LEN_W-1:0]          len_one;
        logic [LEN_W-1:0]          len_two;
    } curve_cfg_t;

    typedef struct packed {
        logic  start;
        wide_t a;
        wide_t b;
        wide_t d;
    } mdv_req_t;

    typedef struct packed {
        logic  done;
        logic  clip;
        wide_t q;
    } mdv_rsp_t;

    typedef struct packed {
        logic busy;
        logic derive_done;
    } seq_stat_t;

    typedef enum logic [1:0] {
        MDV_IDLE,
        MDV_MUL,
        MDV_DIV,
        MDV_FIN
    } mdv_state_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_EG,
        SEQ_XG,
        SEQ_PA,
        SEQ_PB,
        SEQ_AB,
        SEQ_H,
        SEQ_TG,
        SEQ_SEL,
        SEQ_P1,
        SEQ_P2,
        SEQ_P3,
        SEQ_P4,
        SEQ_ELEV
    } seq_state_t;

    // saturating add or subtract; returns {clipped, value}
    function automatic logic [WIDE_W:0] sat_addsub(wide_t a, wide_t b, logic sub);
        logic signed [WIDE_W:0] s;
        s = sub ? ({a[WIDE_W-1], a} - {b[WIDE_W-1], b})
                : ({a[WIDE_W-1], a} + {b[WIDE_W-1], b});
        if (s[WIDE_W] != s[WIDE_W-1])
            return {1'b1, (s[WIDE_W] ? WIDE_MIN : WIDE_MAX)};
        return {1'b0, s[WIDE_W-1:0]};
    endfunction

    function automatic logic [GRADE_W:0] clip_grade(wide_t v);
        logic fits;
        fits = (v[WIDE_W-1:GRADE_W-1] == '0) || (v[WIDE_W-1:GRADE_W-1] == '1);
        if (!fits)
            return {1'b1, v[WIDE_W-1], {(GRADE_W-1){~v[WIDE_W-1]}}};
        return {1'b0, v[GRADE_W-1:0]};
    endfunction

    function automatic logic [COORD_W:0] clip_coord(wide_t v);
        logic fits;
        fits = (v[WIDE_W-1:COORD_W-1] == '0) || (v[WIDE_W-1:COORD_W-1] == '1);
        if (!fits)
            return {1'b1, v[WIDE_W-1], {(COORD_W-1){~v[WIDE_W-1]}}};
        return {1'b0, v[COORD_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vceg_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// round(a*b/d), ties away from zero, clipped to 64 bits; d of zero gives zero
module vceg_muldiv import vceg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mdv_req_t req,
    output mdv_rsp_t      rsp
);

    mdv_state_t state_reg, state_next;
    logic neg_reg, neg_next;
    logic [WIDE_W-1:0] ua_reg, ua_next, ub_reg, ub_next, ud_reg, ud_next;
    logic [2*WIDE_W-1:0] p_reg, p_next;
    logic [WIDE_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mdv_rsp_t rsp_reg, rsp_next;

    logic [WIDE_W/2-1:0] a_half, b_half;
    logic [WIDE_W-1:0] pp;
    logic [2*WIDE_W-1:0] pp_shifted;
    logic [1:0] pp_pos;
    logic [WIDE_W-1:0] rs;
    logic take;
    logic rnd;
    logic [2*WIDE_W-1:0] qi;

    function automatic logic [WIDE_W-1:0] mag(wide_t v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MDV_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        ud_reg  <= ud_next;
        p_reg   <= p_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        ud_next    = ud_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        rsp_next.done = 1'b0;

        // one 32x32 partial product per cycle
        a_half = cnt_reg[1] ? ua_reg[WIDE_W-1:WIDE_W/2] : ua_reg[WIDE_W/2-1:0];
        b_half = cnt_reg[0] ? ub_reg[WIDE_W-1:WIDE_W/2] : ub_reg[WIDE_W/2-1:0];
        pp     = a_half * b_half;
        pp_pos = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        pp_shifted = {{WIDE_W{1'b0}}, pp} << {pp_pos, 5'b0};

        rs   = {r_reg[WIDE_W-2:0], p_reg[2*WIDE_W-1]};
        take = r_reg[WIDE_W-1] || (rs >= ud_reg);
        rnd  = (r_reg >= (ud_reg - r_reg));
        qi   = p_reg + {{(2*WIDE_W-1){1'b0}}, rnd};

        case (state_reg)
            MDV_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = (req.a[WIDE_W-1] ^ req.b[WIDE_W-1]) ^ req.d[WIDE_W-1];
                    ua_next  = mag(req.a);
                    ub_next  = mag(req.b);
                    ud_next  = mag(req.d);
                    p_next   = '0;
                    cnt_next = '0;
                    state_next = MDV_MUL;
                end
            end
            MDV_MUL:
            begin
                p_next   = p_reg + pp_shifted;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[1] && cnt_reg[0])
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    // a divisor of one leaves the product as the quotient
                    state_next = (ud_reg > WIDE_W'(1)) ? MDV_DIV : MDV_FIN;
                end
            end
            MDV_DIV:
            begin
                r_next   = take ? (rs - ud_reg) : rs;
                p_next   = {p_reg[2*WIDE_W-2:0], take};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = MDV_FIN;
            end
            MDV_FIN:
            begin
                rsp_next.done = 1'b1;
                rsp_next.clip = 1'b0;
                if (ud_reg == '0)
                    rsp_next.q = '0;
                else if (neg_reg)
                begin
                    if ((qi[2*WIDE_W-1:WIDE_W] != '0) ||
                        (qi[WIDE_W-1:0] > WIDE_W'(WIDE_MIN)))
                    begin
                        rsp_next.clip = 1'b1;
                        rsp_next.q    = WIDE_MIN;
                    end
                    else
                        rsp_next.q = -wide_t'(qi[WIDE_W-1:0]);
                end
                else
                begin
                    if ((qi[2*WIDE_W-1:WIDE_W] != '0) || qi[WIDE_W-1])
                    begin
                        rsp_next.clip = 1'b1;
                        rsp_next.q    = WIDE_MAX;
                    end
                    else
                        rsp_next.q = wide_t'(qi[WIDE_W-1:0]);
                end
                state_next = MDV_IDLE;
            end
            default:
            begin
                state_next = MDV_IDLE;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/vceg_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vceg_seq import vceg_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [COORD_W-1:0] query_station,
    input  wire curve_cfg_t                cfg,
    input  wire logic                      stale,
    input  wire mdv_rsp_t                  rsp,
    output mdv_req_t                       req,
    output seq_stat_t                      stat,
    output logic                           done,
    output logic signed [COORD_W-1:0]      elevation,
    output logic signed [GRADE_W-1:0]      grade,
    output logic                           curve_invalid,
    output logic                           saturated
);

    seq_state_t state_reg, state_next;
    logic issued_reg, issued_next;
    logic done_reg, done_next;

    wide_t sq_reg, sq_next;
    logic signed [GRADE_W-1:0] eg_reg, eg_next, xg_reg, xg_next, tg_reg, tg_next;
    logic [LEN_W:0] a_reg, a_next, b_reg, b_next;
    wide_t pvi_sta_reg, pvi_sta_next, bvc_sta_reg, bvc_sta_next, evc_sta_reg, evc_sta_next;
    wide_t pvi_lvl_reg, pvi_lvl_next, bvc_lvl_reg, bvc_lvl_next, evc_lvl_reg, evc_lvl_next;
    wide_t tel_reg, tel_next;
    wide_t pa_reg, pa_next, pb_reg, pb_next, tmp_reg, tmp_next;
    logic shape_reg, shape_next, dclip_reg, dclip_next, qclip_reg, qclip_next;
    logic tan_reg, tan_next;
    wide_t x_reg, x_next, e_reg, e_next;
    logic signed [GRADE_W-1:0] g0_reg, g0_next, g_reg, g_next;
    logic signed [GRADE_W:0] dg_reg, dg_next;
    logic [LEN_W:0] span_reg, span_next;

    logic signed [COORD_W-1:0] elev_out_reg, elev_out_next;
    logic signed [GRADE_W-1:0] grade_out_reg, grade_out_next;
    logic inv_out_reg, inv_out_next, sat_out_reg, sat_out_next;

    logic op_state;
    logic skip_mul;
    logic derive_fin;
    logic [LEN_W:0] a_val, b_val;
    wide_t pvi_sta_val;
    logic [WIDE_W:0] sat_r;
    logic [GRADE_W:0] gclip_r;
    logic [COORD_W:0] eclip_r;
    logic [WIDE_W-1:0] e_mag;
    wide_t e_rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg      <= sq_next;
        eg_reg      <= eg_next;
        xg_reg      <= xg_next;
        tg_reg      <= tg_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        pvi_sta_reg <= pvi_sta_next;
        bvc_sta_reg <= bvc_sta_next;
        evc_sta_reg <= evc_sta_next;
        pvi_lvl_reg <= pvi_lvl_next;
        bvc_lvl_reg <= bvc_lvl_next;
        evc_lvl_reg <= evc_lvl_next;
        tel_reg     <= tel_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        tmp_reg     <= tmp_next;
        shape_reg   <= shape_next;
        dclip_reg   <= dclip_next;
        qclip_reg   <= qclip_next;
        tan_reg     <= tan_next;
        x_reg       <= x_next;
        e_reg       <= e_next;
        g0_reg      <= g0_next;
        g_reg       <= g_next;
        dg_reg      <= dg_next;
        span_reg    <= span_next;
        elev_out_reg  <= elev_out_next;
        grade_out_reg <= grade_out_next;
        inv_out_reg   <= inv_out_next;
        sat_out_reg   <= sat_out_next;
    end

    assign op_state = (state_reg != SEQ_IDLE) && (state_reg != SEQ_SEL) &&
                      (state_reg != SEQ_ELEV);
    // the zero-length side skips its multiply, so drop that start
    assign skip_mul = (state_reg == SEQ_P1) && !tan_reg && (span_reg == '0);

    // operand select for the shared unit
    always_comb
    begin
        req.start = op_state && !issued_reg && !skip_mul;
        req.a = '0;
        req.b = '0;
        req.d = WIDE_ONE;
        case (state_reg)
            SEQ_EG:
            begin
                req.a = wide_t'(cfg.pvi_elev) - wide_t'(cfg.pbg_elev);
                req.b = GRADE_ONE;
                req.d = wide_t'(cfg.pvi_sta) - wide_t'(cfg.pbg_sta);
            end
            SEQ_XG:
            begin
                req.a = wide_t'(cfg.pfg_elev) - wide_t'(cfg.pvi_elev);
                req.b = GRADE_ONE;
                req.d = wide_t'(cfg.pfg_sta) - wide_t'(cfg.pvi_sta);
            end
            SEQ_PA:
            begin
                req.a = wide_t'(eg_reg);
                req.b = wide_t'(a_reg);
            end
            SEQ_PB:
            begin
                req.a = wide_t'(xg_reg);
                req.b = wide_t'(b_reg);
            end
            SEQ_AB:
            begin
                req.a = wide_t'(a_reg);
                req.b = wide_t'(b_reg);
            end
            SEQ_H:
            begin
                req.a = tmp_reg;
                req.b = wide_t'(xg_reg) - wide_t'(eg_reg);
                req.d = (wide_t'(a_reg) + wide_t'(b_reg)) <<< 1;
            end
            SEQ_TG:
            begin
                req.a = pa_reg + pb_reg;
                req.b = WIDE_ONE;
                req.d = wide_t'(a_reg) + wide_t'(b_reg);
            end
            SEQ_P1:
            begin
                req.a = wide_t'(g0_reg);
                req.b = x_reg;
            end
            SEQ_P2:
            begin
                req.a = x_reg;
                req.b = x_reg;
            end
            SEQ_P3:
            begin
                req.a = wide_t'(dg_reg);
                req.b = tmp_reg;
                req.d = wide_t'(span_reg) <<< 1;
            end
            SEQ_P4:
            begin
                req.a = wide_t'(dg_reg);
                req.b = x_reg;
                req.d = wide_t'(span_reg);
            end
            default:
            begin
                req.a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        done_next    = 1'b0;
        sq_next      = sq_reg;
        eg_next      = eg_reg;
        xg_next      = xg_reg;
        tg_next      = tg_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        pvi_sta_next = pvi_sta_reg;
        bvc_sta_next = bvc_sta_reg;
        evc_sta_next = evc_sta_reg;
        pvi_lvl_next = pvi_lvl_reg;
        bvc_lvl_next = bvc_lvl_reg;
        evc_lvl_next = evc_lvl_reg;
        tel_next     = tel_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        tmp_next     = tmp_reg;
        shape_next   = shape_reg;
        dclip_next   = dclip_reg;
        qclip_next   = qclip_reg;
        tan_next     = tan_reg;
        x_next       = x_reg;
        e_next       = e_reg;
        g0_next      = g0_reg;
        g_next       = g_reg;
        dg_next      = dg_reg;
        span_next    = span_reg;
        elev_out_next  = elev_out_reg;
        grade_out_next = grade_out_reg;
        inv_out_next   = inv_out_reg;
        sat_out_next   = sat_out_reg;
        derive_fin   = 1'b0;

        // symmetric curve splits length_one about the PVI; stations in half mm
        a_val = (cfg.len_two == '0) ? {1'b0, cfg.len_one} : {cfg.len_one, 1'b0};
        b_val = (cfg.len_two == '0) ? {1'b0, cfg.len_one} : {cfg.len_two, 1'b0};
        pvi_sta_val = wide_t'(cfg.pvi_sta) <<< 1;

        sat_r   = '0;
        gclip_r = '0;
        eclip_r = '0;
        e_mag   = '0;
        e_rnd   = '0;

        if (req.start)
            issued_next = 1'b1;
        if (rsp.done)
            issued_next = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    sq_next    = wide_t'(query_station) <<< 1;
                    qclip_next = 1'b0;
                    if (stale)
                    begin
                        dclip_next = 1'b0;
                        shape_next = ((cfg.len_one == '0) && (cfg.len_two != '0)) ||
                                     (cfg.pvi_sta < cfg.pbg_sta) ||
                                     (cfg.pfg_sta < cfg.pvi_sta);
                        a_next       = a_val;
                        b_next       = b_val;
                        pvi_sta_next = pvi_sta_val;
                        bvc_sta_next = pvi_sta_val - wide_t'(a_val);
                        evc_sta_next = pvi_sta_val + wide_t'(b_val);
                        pvi_lvl_next = wide_t'(cfg.pvi_elev) <<< (GRADE_FRAC + 1);
                        state_next   = SEQ_EG;
                    end
                    else
                        state_next = SEQ_SEL;
                end
            end
            SEQ_EG:
            begin
                if (rsp.done)
                begin
                    gclip_r    = clip_grade(rsp.q);
                    eg_next    = gclip_r[GRADE_W-1:0];
                    dclip_next = dclip_reg | rsp.clip | gclip_r[GRADE_W];
                    state_next = SEQ_XG;
                end
            end
            SEQ_XG:
            begin
                if (rsp.done)
                begin
                    gclip_r    = clip_grade(rsp.q);
                    xg_next    = gclip_r[GRADE_W-1:0];
                    dclip_next = dclip_reg | rsp.clip | gclip_r[GRADE_W];
                    state_next = SEQ_PA;
                end
            end
            SEQ_PA:
            begin
                if (rsp.done)
                begin
                    sat_r        = sat_addsub(pvi_lvl_reg, rsp.q, 1'b1);
                    pa_next      = rsp.q;
                    bvc_lvl_next = sat_r[WIDE_W-1:0];
                    dclip_next   = dclip_reg | rsp.clip | sat_r[WIDE_W];
                    state_next   = SEQ_PB;
                end
            end
            SEQ_PB:
            begin
                if (rsp.done)
                begin
                    sat_r        = sat_addsub(pvi_lvl_reg, rsp.q, 1'b0);
                    pb_next      = rsp.q;
                    evc_lvl_next = sat_r[WIDE_W-1:0];
                    dclip_next   = dclip_reg | rsp.clip | sat_r[WIDE_W];
                    state_next   = SEQ_AB;
                end
            end
            SEQ_AB:
            begin
                if (rsp.done)
                begin
                    tmp_next   = rsp.q;
                    dclip_next = dclip_reg | rsp.clip;
                    state_next = SEQ_H;
                end
            end
            SEQ_H:
            begin
                if (rsp.done)
                begin
                    sat_r      = sat_addsub(pvi_lvl_reg, rsp.q, 1'b0);
                    tel_next   = sat_r[WIDE_W-1:0];
                    dclip_next = dclip_reg | rsp.clip | sat_r[WIDE_W];
                    if (a_reg == '0)
                    begin
                        // no left parabola: transition keeps the entry grade
                        tg_next    = eg_reg;
                        derive_fin = 1'b1;
                        state_next = SEQ_SEL;
                    end
                    else
                        state_next = SEQ_TG;
                end
            end
            SEQ_TG:
            begin
                if (rsp.done)
                begin
                    gclip_r    = clip_grade(rsp.q);
                    tg_next    = gclip_r[GRADE_W-1:0];
                    dclip_next = dclip_reg | rsp.clip | gclip_r[GRADE_W];
                    derive_fin = 1'b1;
                    state_next = SEQ_SEL;
                end
            end
            SEQ_SEL:
            begin
                if (sq_reg < bvc_sta_reg)
                begin
                    tan_next = 1'b1;
                    x_next   = sq_reg - bvc_sta_reg;
                    e_next   = bvc_lvl_reg;
                    g0_next  = eg_reg;
                end
                else if (sq_reg > evc_sta_reg)
                begin
                    tan_next = 1'b1;
                    x_next   = sq_reg - evc_sta_reg;
                    e_next   = evc_lvl_reg;
                    g0_next  = xg_reg;
                end
                else if (sq_reg < pvi_sta_reg)
                begin
                    tan_next  = 1'b0;
                    x_next    = sq_reg - bvc_sta_reg;
                    e_next    = bvc_lvl_reg;
                    g0_next   = eg_reg;
                    dg_next   = {tg_reg[GRADE_W-1], tg_reg} - {eg_reg[GRADE_W-1], eg_reg};
                    span_next = a_reg;
                end
                else
                begin
                    tan_next  = 1'b0;
                    x_next    = sq_reg - pvi_sta_reg;
                    e_next    = tel_reg;
                    g0_next   = tg_reg;
                    dg_next   = {xg_reg[GRADE_W-1], xg_reg} - {tg_reg[GRADE_W-1], tg_reg};
                    span_next = b_reg;
                end
                state_next = SEQ_P1;
            end
            SEQ_P1:
            begin
                // a zero-length side holds its start point
                if (!tan_reg && (span_reg == '0))
                begin
                    g_next     = g0_reg;
                    state_next = SEQ_ELEV;
                end
                else if (rsp.done)
                begin
                    sat_r      = sat_addsub(e_reg, rsp.q, 1'b0);
                    e_next     = sat_r[WIDE_W-1:0];
                    g_next     = g0_reg;
                    qclip_next = qclip_reg | rsp.clip | sat_r[WIDE_W];
                    state_next = tan_reg ? SEQ_ELEV : SEQ_P2;
                end
            end
            SEQ_P2:
            begin
                if (rsp.done)
                begin
                    tmp_next   = rsp.q;
                    qclip_next = qclip_reg | rsp.clip;
                    state_next = SEQ_P3;
                end
            end
            SEQ_P3:
            begin
                if (rsp.done)
                begin
                    sat_r      = sat_addsub(e_reg, rsp.q, 1'b0);
                    e_next     = sat_r[WIDE_W-1:0];
                    qclip_next = qclip_reg | rsp.clip | sat_r[WIDE_W];
                    state_next = SEQ_P4;
                end
            end
            SEQ_P4:
            begin
                if (rsp.done)
                begin
                    gclip_r    = clip_grade(rsp.q + wide_t'(g0_reg));
                    g_next     = gclip_r[GRADE_W-1:0];
                    qclip_next = qclip_reg | rsp.clip | gclip_r[GRADE_W];
                    state_next = SEQ_ELEV;
                end
            end
            SEQ_ELEV:
            begin
                // level to millimetres: round the magnitude at half a step, then shift
                e_mag = e_reg[WIDE_W-1] ? WIDE_W'(-e_reg) : WIDE_W'(e_reg);
                e_rnd = wide_t'((e_mag + WIDE_W'(LEVEL_SCALE >>> 1)) >> (GRADE_FRAC + 1));
                if (e_reg[WIDE_W-1])
                    e_rnd = -e_rnd;
                eclip_r        = clip_coord(e_rnd);
                elev_out_next  = eclip_r[COORD_W-1:0];
                grade_out_next = g_reg;
                inv_out_next   = shape_reg;
                sat_out_next   = qclip_reg | eclip_r[COORD_W] | dclip_reg;
                done_next      = 1'b1;
                state_next     = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign stat.busy        = (state_reg != SEQ_IDLE);
    assign stat.derive_done = derive_fin;

    assign done          = done_reg;
    assign elevation     = elev_out_reg;
    assign grade         = grade_out_reg;
    assign curve_invalid = inv_out_reg;
    assign saturated     = sat_out_reg;

endmodule

`default_nettype wire

// ----- rtl/vertical_curve_elevation_grade.sv -----
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// query    | start, accepted when !busy    | query_station
// result   | done, one-cycle strobe        | elevation, grade, curve_invalid, saturated
// config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One query at a time. Every multiply and divide runs through one shared unit:
// four 32x32 partial products, plus a 128-step restoring divide unless the
// divisor is 0 or +-1. A tangent query uses the unit once, a parabola query
// up to four times; the final scaling to millimetres is a rounded shift.
// The first query after a register write first re-derives the cached curve.
// Reset (rst_n low, asynchronous) clears the registers to zero and marks the
// curve for derivation. The receiver cannot stall: done is high for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module vertical_curve_elevation_grade import vceg_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] query_station,
    output logic                           done,
    output logic signed [COORD_W-1:0]      elevation,
    output logic signed [GRADE_W-1:0]      grade,
    output logic                           curve_invalid,
    output logic                           saturated,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [IDX_W-1:0]          cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_data
);

    curve_cfg_t cfg_reg, cfg_next;
    logic       stale_reg, stale_next;

    mdv_req_t   md_req;
    mdv_rsp_t   md_rsp;
    seq_stat_t  seq_stat;

    // configuration is taken any time; the contract keeps writes to idle periods
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            stale_reg <= 1'b1;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            stale_reg <= stale_next;
        end
    end

    always_comb
    begin
        cfg_next   = cfg_reg;
        stale_next = stale_reg;
        // clear once the cached curve is rebuilt
        if (seq_stat.derive_done)
            stale_next = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            // any write inside the register list marks the cache stale;
            // an index beyond the list is dropped
            case (reg_idx_t'(cfg_index))
                REG_PBG_STA:
                begin
                    cfg_next.pbg_sta = cfg_data;
                    stale_next = 1'b1;
                end
                REG_PBG_ELEV:
                begin
                    cfg_next.pbg_elev = cfg_data;
                    stale_next = 1'b1;
                end
                REG_PVI_STA:
                begin
                    cfg_next.pvi_sta = cfg_data;
                    stale_next = 1'b1;
                end
                REG_PVI_ELEV:
                begin
                    cfg_next.pvi_elev = cfg_data;
                    stale_next = 1'b1;
                end
                REG_PFG_STA:
                begin
                    cfg_next.pfg_sta = cfg_data;
                    stale_next = 1'b1;
                end
                REG_PFG_ELEV:
                begin
                    cfg_next.pfg_elev = cfg_data;
                    stale_next = 1'b1;
                end
                REG_LEN_ONE:
                begin
                    cfg_next.len_one = cfg_data[LEN_W-1:0];
                    stale_next = 1'b1;
                end
                REG_LEN_TWO:
                begin
                    cfg_next.len_two = cfg_data[LEN_W-1:0];
                    stale_next = 1'b1;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // sequencer: derivation of the cached curve when it is stale, then region select and evaluation
    vceg_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .query_station (query_station),
        .cfg           (cfg_reg),
        .stale         (stale_reg),
        .rsp           (md_rsp),
        .req           (md_req),
        .stat          (seq_stat),
        .done          (done),
        .elevation     (elevation),
        .grade         (grade),
        .curve_invalid (curve_invalid),
        .saturated     (saturated)
    );

    // shared multiply-divide unit with rounding and 64-bit clipping
    vceg_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign busy = seq_stat.busy;

endmodule

`default_nettype wire

// ----- rtl/vceg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vceg_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // an accepted transaction holds the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // no result can follow acceptance by a single cycle
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe one cycle after acceptance");

    // a result closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind vertical_curve_elevation_grade vceg_checker u_vceg_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

// ----- sim/vceg_checker.sv -----
`timescale 1ns / 1ps

module vceg_scoreboard import vceg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [COORD_W-1:0] query_station,
    input  logic                      done,
    input  logic signed [COORD_W-1:0] elevation,
    input  logic signed [GRADE_W-1:0] grade,
    input  logic                      curve_invalid,
    input  logic                      saturated,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic signed [COORD_W-1:0] elevation;
        logic signed [GRADE_W-1:0] grade;
        logic                      curve_invalid;
        logic                      saturated;
    } profile_point_t;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    profile_point_t expected_points[$];

    logic [COORD_W-1:0] curve_regs [NUM_REGS];
    logic   needs_derive;
    int     g_entry, g_exit, g_trans;
    longint bvc_sta, bvc_lvl, evc_sta, evc_lvl, pvi_sta, pvi_lvl, trans_lvl;
    longint span_l, span_r;
    logic   bad_shape, derive_clipped, clip_seen;

    function automatic logic [127:0] mag128(longint v);
        logic signed [127:0] t;
        t = v;
        return (t < 0) ? -t : t;
    endfunction

    // round(a*b/d) ties away from zero, clipped to 64 bits; zero divisor gives 0
    function automatic longint scale_div(longint a, longint b, longint d);
        logic [127:0] p, q, r, ud;
        logic neg;
        if (d == 0)
            return 0;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        ud = mag128(d);
        p = mag128(a) * mag128(b);
        q = p / ud;
        r = p % ud;
        if (r >= ud - r)
            q = q + 1;
        if (neg) begin
            if (q > 128'h8000_0000_0000_0000) begin
                clip_seen = 1'b1;
                return I64_MIN;
            end
            return -longint'(q[63:0]);
        end
        if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
            clip_seen = 1'b1;
            return I64_MAX;
        end
        return longint'(q[63:0]);
    endfunction

    function automatic longint add_clip(longint a, longint b);
        if (b > 0 && a > I64_MAX - b) begin
            clip_seen = 1'b1;
            return I64_MAX;
        end
        if (b < 0 && a < I64_MIN - b) begin
            clip_seen = 1'b1;
            return I64_MIN;
        end
        return a + b;
    endfunction

    function automatic longint sub_clip(longint a, longint b);
        if (b < 0 && a > I64_MAX + b) begin
            clip_seen = 1'b1;
            return I64_MAX;
        end
        if (b > 0 && a < I64_MIN + b) begin
            clip_seen = 1'b1;
            return I64_MIN;
        end
        return a - b;
    endfunction

    function automatic int grade_clip(longint v);
        if (v > 64'sh7FFF_FFFF) begin
            clip_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clip_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    function automatic longint coord(reg_idx_t i);
        return longint'($signed(curve_regs[i]));
    endfunction

    function automatic void derive_profile();
        longint pbs, pbe, pvs, pve, pfs, pfe, l1, l2, h, unit_g, lvl_scale;
        pbs = coord(REG_PBG_STA);
        pbe = coord(REG_PBG_ELEV);
        pvs = coord(REG_PVI_STA);
        pve = coord(REG_PVI_ELEV);
        pfs = coord(REG_PFG_STA);
        pfe = coord(REG_PFG_ELEV);
        l1 = longint'(curve_regs[REG_LEN_ONE]);
        l2 = longint'(curve_regs[REG_LEN_TWO]);
        unit_g = 64'sd1 <<< GRADE_FRAC;
        lvl_scale = 64'sd1 <<< (GRADE_FRAC + 1);
        clip_seen = 1'b0;
        bad_shape = (l1 == 0 && l2 != 0) || pvs < pbs || pfs < pvs;
        g_entry = grade_clip(pvs == pbs ? 0 : scale_div(pve - pbe, unit_g, pvs - pbs));
        g_exit = grade_clip(pfs == pvs ? 0 : scale_div(pfe - pve, unit_g, pfs - pvs));
        if (l2 == 0) begin
            span_l = l1;
            span_r = l1;
        end
        else begin
            span_l = 2 * l1;
            span_r = 2 * l2;
        end
        pvi_sta = 2 * pvs;
        pvi_lvl = scale_div(pve, lvl_scale, 1);
        bvc_sta = pvi_sta - span_l;
        bvc_lvl = sub_clip(pvi_lvl, scale_div(g_entry, span_l, 1));
        evc_sta = pvi_sta + span_r;
        evc_lvl = add_clip(pvi_lvl, scale_div(g_exit, span_r, 1));
        h = (span_l + span_r == 0) ? 0 : scale_div(span_l * span_r,
            longint'(g_exit) - g_entry, 2 * (span_l + span_r));
        trans_lvl = add_clip(pvi_lvl, h);
        g_trans = (span_l == 0) ? g_entry
            : grade_clip(scale_div(span_l * g_entry + span_r * g_exit, 1, span_l + span_r));
        derive_clipped = clip_seen;
        needs_derive = 1'b0;
    endfunction

    function automatic profile_point_t evaluate_station(logic signed [COORD_W-1:0] qs);
        longint sq, e, elev, x, dg, lim;
        int g;
        profile_point_t pt;
        if (needs_derive)
            derive_profile();
        clip_seen = 1'b0;
        lim = 64'sd1 <<< (COORD_W - 1);
        sq = 2 * longint'(qs);
        if (sq < bvc_sta) begin
            e = add_clip(bvc_lvl, scale_div(g_entry, sq - bvc_sta, 1));
            g = g_entry;
        end
        else if (sq > evc_sta) begin
            e = add_clip(evc_lvl, scale_div(g_exit, sq - evc_sta, 1));
            g = g_exit;
        end
        else if (sq < pvi_sta) begin
            x = sq - bvc_sta;
            dg = longint'(g_trans) - g_entry;
            if (span_l == 0) begin
                e = bvc_lvl;
                g = g_entry;
            end
            else begin
                e = add_clip(add_clip(bvc_lvl, scale_div(g_entry, x, 1)),
                             scale_div(dg, x * x, 2 * span_l));
                g = grade_clip(scale_div(dg, x, span_l) + g_entry);
            end
        end
        else begin
            x = sq - pvi_sta;
            dg = longint'(g_exit) - g_trans;
            if (span_r == 0) begin
                e = trans_lvl;
                g = g_trans;
            end
            else begin
                e = add_clip(add_clip(trans_lvl, scale_div(g_trans, x, 1)),
                             scale_div(dg, x * x, 2 * span_r));
                g = grade_clip(scale_div(dg, x, span_r) + g_trans);
            end
        end
        elev = scale_div(e, 1, 64'sd1 <<< (GRADE_FRAC + 1));
        if (elev > lim - 1) begin
            elev = lim - 1;
            clip_seen = 1'b1;
        end
        if (elev < -lim) begin
            elev = -lim;
            clip_seen = 1'b1;
        end
        pt.elevation = elev[COORD_W-1:0];
        pt.grade = g;
        pt.curve_invalid = bad_shape;
        pt.saturated = clip_seen || derive_clipped;
        return pt;
    endfunction

    assign pending = expected_points.size();

    always @(posedge clk or negedge rst_n) begin
        profile_point_t want;
        int bad;
        bad = 0;
        if (!rst_n) begin
            for (int i = 0; i < NUM_REGS; i++)
                curve_regs[i] = '0;
            needs_derive = 1'b1;
            g_entry = 0; g_exit = 0; g_trans = 0;
            bvc_sta = 0; bvc_lvl = 0; evc_sta = 0; evc_lvl = 0;
            pvi_sta = 0; pvi_lvl = 0; trans_lvl = 0; span_l = 0; span_r = 0;
            bad_shape = 1'b0; derive_clipped = 1'b0; clip_seen = 1'b0;
            expected_points.delete();
            errors <= 0;
        end
        else begin
            if (done) begin
                if (expected_points.size() == 0) begin
                    $error("result with no query outstanding");
                    bad++;
                end
                else begin
                    want = expected_points.pop_front();
                    if (elevation !== want.elevation) begin
                        $error("elevation: expected %0d, got %0d", want.elevation, elevation);
                        bad++;
                    end
                    if (grade !== want.grade) begin
                        $error("grade: expected %0d, got %0d", want.grade, grade);
                        bad++;
                    end
                    if (curve_invalid !== want.curve_invalid) begin
                        $error("curve_invalid: expected %0b, got %0b",
                               want.curve_invalid, curve_invalid);
                        bad++;
                    end
                    if (saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            if (start && !busy)
                expected_points.push_back(evaluate_station(query_station));
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
                curve_regs[cfg_index[2:0]] =
                    (cfg_index == REG_LEN_ONE || cfg_index == REG_LEN_TWO)
                    ? (cfg_data & {{(COORD_W-LEN_W){1'b0}}, {LEN_W{1'b1}}}) : cfg_data;
                needs_derive = 1'b1;
            end
        end
    end

endmodule

// ----- sim/tb_vertical_curve_elevation_grade.sv -----
`timescale 1ns / 1ps

module tb_vertical_curve_elevation_grade;
    import vceg_pkg::*;

    // Index past the register list; the block must drop writes to it.
    localparam logic [IDX_W-1:0] IDX_UNMAPPED = 4'd11;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] query_station;
    logic                      done;
    logic signed [COORD_W-1:0] elevation;
    logic signed [GRADE_W-1:0] grade;
    logic                      curve_invalid;
    logic                      saturated;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index;
    logic [COORD_W-1:0]        cfg_data;
    int                        errors;
    int                        pending;

    // Current curve as written, used to aim queries at the parabolas.
    int  aim_pvi;
    int  aim_len_one;
    int  aim_len_two;
    int  queries_sent;
    int  curves_loaded;
    bit  no_gaps;

    vertical_curve_elevation_grade dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .query_station (query_station),
        .done          (done),
        .elevation     (elevation),
        .grade         (grade),
        .curve_invalid (curve_invalid),
        .saturated     (saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vceg_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .query_station (query_station),
        .done          (done),
        .elevation     (elevation),
        .grade         (grade),
        .curve_invalid (curve_invalid),
        .saturated     (saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the run hangs.
    initial
    begin
        #30_000_000;
        $display("vertical_curve_elevation_grade regression: fail");
        $finish;
    end

    // Drive one query; entered at a falling edge, returns at one.
    // Hold start high across back-to-back transactions instead of dropping it.
    task automatic send_query(input logic signed [COORD_W-1:0] qs);
        int gap;
        start <= 1'b1;
        query_station <= qs;
        do
            @(posedge clk);
        while (busy);
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        queries_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            query_station <= $urandom;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Write one register; entered and left at a falling edge.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
    endtask

    // Drain every outstanding query before touching the registers.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic load_curve(input int kind);
        int pbs, pbe, pvs, pve, pfs, pfe, l1, l2;
        pvs = $urandom_range(0, 1 << 26) - (1 << 25);
        pve = $urandom_range(0, 1 << 22) - (1 << 21);
        pbs = pvs - $urandom_range(0, 1 << 24);
        pfs = pvs + $urandom_range(0, 1 << 24);
        pbe = pve + $urandom_range(0, 1 << 20) - (1 << 19);
        pfe = pve + $urandom_range(0, 1 << 20) - (1 << 19);
        l1 = $urandom_range(1, 1 << 22);
        l2 = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 22);
        case (kind)
            0:
            begin
                // Reset-equivalent curve: everything at zero.
                pbs = 0; pbe = 0; pvs = 0; pve = 0; pfs = 0; pfe = 0; l1 = 0; l2 = 0;
            end
            1:
            begin
                // Widest legal curve with steep opposing grades: forces clipping.
                pbs = 32'h8000_0000; pbe = 32'h7FFF_FFFF; pvs = 0; pve = 32'h8000_0000;
                pfs = 32'h7FFF_FFFF; pfe = 32'h7FFF_FFFF; l1 = LEN_MAX; l2 = LEN_MAX;
            end
            2: l2 = 0;
            3: l1 = 0;
            4:
            begin
                l1 = 0;
                l2 = 0;
            end
            5:
            begin
                // Coincident grade points give zero-run grades.
                pbs = pvs;
                pfs = pvs;
            end
            6:
            begin
                // Stations out of order.
                pbs = pvs + 1000;
                pfs = pvs - 1000;
            end
            7:
            begin
                // Steep grades over a one-millimetre run.
                pbs = pvs - 1; pfs = pvs + 1;
                pbe = 32'h8000_0000; pfe = 32'h8000_0000; pve = 32'h7FFF_FFFF;
                l1 = 1; l2 = 0;
            end
            8:
            begin
                // Any bit pattern at all; shape often invalid.
                pbs = $urandom; pbe = $urandom; pvs = $urandom; pve = $urandom;
                pfs = $urandom; pfe = $urandom; l1 = $urandom; l2 = $urandom;
            end
            default: ;
        endcase
        wait_idle();
        write_reg(REG_PBG_STA, pbs);
        write_reg(REG_PBG_ELEV, pbe);
        write_reg(REG_PVI_STA, pvs);
        write_reg(REG_PVI_ELEV, pve);
        write_reg(REG_PFG_STA, pfs);
        write_reg(REG_PFG_ELEV, pfe);
        write_reg(REG_LEN_ONE, l1);
        write_reg(REG_LEN_TWO, l2);
        if ($urandom_range(0, 3) == 0)
            write_reg(IDX_UNMAPPED, $urandom);
        aim_pvi = pvs;
        aim_len_one = l1 & LEN_MAX;
        aim_len_two = l2 & LEN_MAX;
        curves_loaded++;
    endtask

    // Mostly stations on or near the curve, some on the boundaries, some anywhere.
    function automatic int pick_station();
        int reach, sel;
        reach = aim_len_one + aim_len_two + 16;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return aim_pvi + $urandom_range(0, 2 * reach) - reach;
        case (sel)
            14: return aim_pvi;
            15: return aim_pvi - aim_len_one;
            16: return aim_pvi + aim_len_two;
            17: return aim_pvi - aim_len_one / 2;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        query_station = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PBG_STA;
        cfg_data = '0;
        aim_pvi = 0; aim_len_one = 0; aim_len_two = 0;
        queries_sent = 0; curves_loaded = 0; no_gaps = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset curve at the station extremes, then each special shape.
        send_query(32'sh0);
        send_query(32'sh7FFF_FFFF);
        send_query(32'sh8000_0000);
        for (int k = 1; k <= 8; k++)
        begin
            load_curve(k);
            send_query(aim_pvi);
            send_query(pick_station());
        end

        // Random: mostly well-formed curves, with a randomly chosen shape on every fourth load.
        for (int ph = 0; ph < 22; ph++)
        begin
            load_curve((ph % 4 == 3) ? $urandom_range(0, 8) : 9);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 25; n++)
                send_query(pick_station());
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("covered %0d queries over %0d curve loads (tangents, both parabolas,",
                 queries_sent, curves_loaded);
        $display("zero-length, symmetric, invalid and clipping shapes)");
        if (errors == 0)
            $display("vertical_curve_elevation_grade regression: pass");
        else
            $display("vertical_curve_elevation_grade regression: fail");
        $finish;
    end

endmodule
